// ===== sv/mbps_pkg.sv =====
// Shared constants, register indexes and types for the masked byte pattern scanner.
package mbps_pkg;

	localparam int MAX_PATTERN = 32;
	localparam int OFFSET_BITS = 32;

	// Window depth: the pattern registers hold at most 32 bytes.
	localparam int PAT_CAP = (MAX_PATTERN < 32) ? MAX_PATTERN : 32;
	localparam int FILL_W = $clog2(PAT_CAP + 1);

	localparam int WORD_W = 64;
	localparam int NUM_WORDS = 4;
	localparam int MASK_W = 32;
	localparam int LEN_W = 6;
	localparam int OFF_OUT_W = 32;
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_PATTERN_0 = 3'd0;
	localparam logic [IDX_W-1:0] REG_PATTERN_1 = 3'd1;
	localparam logic [IDX_W-1:0] REG_PATTERN_2 = 3'd2;
	localparam logic [IDX_W-1:0] REG_PATTERN_3 = 3'd3;
	localparam logic [IDX_W-1:0] REG_CARE_MASK = 3'd4;
	localparam logic [IDX_W-1:0] REG_LENGTH = 3'd5;

	typedef struct packed {
		logic [NUM_WORDS-1:0][WORD_W-1:0] pattern;
		logic [MASK_W-1:0] care;
		logic [LEN_W-1:0] length;
	} cfg_t;

	typedef struct packed {
		logic found;
		logic [OFF_OUT_W-1:0] offset;
	} res_t;

endpackage

// ===== sv/mbps_cmp.sv =====
// Masked compare of the shifted byte window against the configured pattern.
module mbps_cmp (
	input  mbps_pkg::cfg_t                       cfg,
	input  logic [7:0]                           win [mbps_pkg::PAT_CAP],
	input  logic [mbps_pkg::FILL_W-1:0]          fill,
	input  logic [mbps_pkg::OFFSET_BITS-1:0]     pos,
	output logic                                 hit,
	output logic [mbps_pkg::OFF_OUT_W-1:0]       offset
);

	logic [mbps_pkg::LEN_W-1:0] len_eff;
	logic [mbps_pkg::PAT_CAP-1:0] byte_ok;
	logic [mbps_pkg::OFFSET_BITS-1:0] start;
	logic [63:0] start_ext;

	// Treat zero as one, clamp to the window depth.
	always_comb begin
		if (cfg.length == '0) begin
			len_eff = mbps_pkg::LEN_W'(1);
		end else if (7'(cfg.length) > 7'(mbps_pkg::PAT_CAP)) begin
			len_eff = mbps_pkg::LEN_W'(mbps_pkg::PAT_CAP);
		end else begin
			len_eff = cfg.length;
		end
	end

	// Window entry k lines up with pattern byte len-1-k; the pattern ends at the newest byte.
	genvar k;
	for (k = 0; k < mbps_pkg::PAT_CAP; k++) begin : g_lane
		logic [mbps_pkg::LEN_W-1:0] idx;
		logic in_use;
		logic [7:0] pbyte;

		assign in_use = 7'(k) < 7'(len_eff);
		assign idx = len_eff - mbps_pkg::LEN_W'(k + 1);
		assign pbyte = cfg.pattern[idx[4:3]][{idx[2:0], 3'b000} +: 8];
		assign byte_ok[k] = !in_use || !cfg.care[idx[4:0]] || (win[k] == pbyte);
	end

	assign hit = (7'(fill) >= 7'(len_eff)) && (&byte_ok);

	assign start = pos - mbps_pkg::OFFSET_BITS'(len_eff - mbps_pkg::LEN_W'(1));
	assign start_ext = 64'(start);
	assign offset = (start_ext > 64'h0000_0000_FFFF_FFFF) ? '1 : start_ext[31:0];

endmodule

// ===== sv/mbps_skid.sv =====
// Output register with a skid stage for the result stream.
module mbps_skid (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mbps_pkg::res_t  push_res,
	output logic            push_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output mbps_pkg::res_t  out_res
);

	logic out_valid_q;
	logic skid_valid_q;
	mbps_pkg::res_t out_res_q;
	mbps_pkg::res_t skid_res_q;
	logic out_free;

	assign push_ready = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res = out_res_q;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			priority if (out_free && skid_valid_q) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else if (out_free) begin
				out_valid_q <= push;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end else begin
				// hold
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (out_free && skid_valid_q) begin
			out_res_q <= skid_res_q;
		end else if (out_free && push) begin
			out_res_q <= push_res;
		end else if (push) begin
			skid_res_q <= push_res;
		end else begin
			// hold
		end
	end

endmodule

// ===== sv/masked_byte_pattern_scan.sv =====
// Top level of the masked byte pattern scanner: registers, window, region state.
//
//  channel  | dir | handshake          | payload
//  s_*      | in  | s_tvalid/s_tready  | s_tdata = data_byte, s_tlast = last_byte
//  m_*      | out | m_tvalid/m_tready  | m_tdata = match_offset, m_tuser = found
//  cfg_*    | in  | cfg_valid/cfg_ready| cfg_index = register, cfg_data = value
//
// One byte is taken every cycle while s_tready is high; the masked compare of all window
// lanes runs in the cycle the byte is taken and the result is registered.
// A result waits in the output register; a second one moves to the skid stage, and
// s_tready drops only while both are full.
// Reset clears the region state and the registers to their defaults (length one).
// cfg_ready is always high; writes to indexes past the list are dropped.
module masked_byte_pattern_scan (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] match_offset
	output logic [0:0]  m_tuser,   // [0] found
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	mbps_pkg::cfg_t cfg_q;
	logic [7:0] win_q [mbps_pkg::PAT_CAP];
	logic [7:0] win_next [mbps_pkg::PAT_CAP];
	logic [mbps_pkg::FILL_W-1:0] fill_q;
	logic [mbps_pkg::FILL_W-1:0] fill_next;
	logic [mbps_pkg::OFFSET_BITS-1:0] pos_q;
	logic [mbps_pkg::OFFSET_BITS-1:0] pos_next;
	logic done_q;

	logic s_fire;
	logic hit;
	logic [mbps_pkg::OFF_OUT_W-1:0] hit_offset;
	logic res_valid;
	mbps_pkg::res_t res;
	mbps_pkg::res_t out_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern <= '0;
			cfg_q.care <= '0;
			cfg_q.length <= mbps_pkg::LEN_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mbps_pkg::REG_PATTERN_0: cfg_q.pattern[0] <= cfg_data;
				mbps_pkg::REG_PATTERN_1: cfg_q.pattern[1] <= cfg_data;
				mbps_pkg::REG_PATTERN_2: cfg_q.pattern[2] <= cfg_data;
				mbps_pkg::REG_PATTERN_3: cfg_q.pattern[3] <= cfg_data;
				mbps_pkg::REG_CARE_MASK: cfg_q.care <= cfg_data[mbps_pkg::MASK_W-1:0];
				mbps_pkg::REG_LENGTH: cfg_q.length <= cfg_data[mbps_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_fire = s_tvalid && s_tready;

	always_comb begin
		win_next[0] = s_tdata;
		for (int k = 1; k < mbps_pkg::PAT_CAP; k++) begin
			win_next[k] = win_q[k-1];
		end
	end

	assign fill_next = (fill_q == mbps_pkg::FILL_W'(mbps_pkg::PAT_CAP)) ?
		fill_q : fill_q + mbps_pkg::FILL_W'(1);
	// Saturate the byte position at all ones.
	assign pos_next = (&pos_q) ? pos_q : pos_q + mbps_pkg::OFFSET_BITS'(1);

	mbps_cmp u_cmp (
		.cfg    (cfg_q),
		.win    (win_next),
		.fill   (fill_next),
		.pos    (pos_q),
		.hit    (hit),
		.offset (hit_offset)
	);

	assign res_valid = s_fire && !done_q && (hit || s_tlast);
	assign res.found = hit;
	assign res.offset = hit ? hit_offset : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pos_q <= '0;
			done_q <= 1'b0;
		end else if (s_fire) begin
			priority if (s_tlast) begin
				// End of region: start over on the next byte.
				fill_q <= '0;
				pos_q <= '0;
				done_q <= 1'b0;
			end else if (!done_q) begin
				fill_q <= fill_next;
				pos_q <= pos_next;
				done_q <= hit;
			end else begin
				// hold: bytes after a match are dropped
			end
		end
	end

	// Entries past the fill count are never compared, so the window needs no clearing.
	always_ff @(posedge clk) begin
		if (s_fire && !done_q) begin
			win_q <= win_next;
		end
	end

	mbps_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res_valid),
		.push_res   (res),
		.push_ready (s_tready),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_res    (out_res)
	);

	assign m_tdata = out_res.offset;
	assign m_tuser[0] = out_res.found;

endmodule

// ===== sv/mbps_check.sv =====
// Port-level checks for the masked byte pattern scanner, bound to the top level.
module mbps_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic [0:0]  m_tuser
);

	// Hold a stalled result.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// A not-found result carries a zero offset.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 32'd0)
		else $error("not-found result with nonzero offset");

	// Input stalls only while a result is waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no pending result");

	// A new result follows an accepted byte.
	a_res_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready))
		else $error("result without an accepted byte");

endmodule

bind masked_byte_pattern_scan mbps_check u_check (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the masked byte pattern scanner.
`timescale 1ns / 100ps

module testbench;

	localparam int HALF_PERIOD = 10;
	localparam int RESET_CYCLES = 12;
	localparam int NUM_PHASES = 13;
	localparam int PHASE_BYTES = 100;
	localparam int PRESSURE_REGIONS = 60;
	localparam int HOLD_CYCLES = 200;
	localparam int SETTLE_CYCLES = 4;
	localparam int WATCHDOG_LIMIT = 2000;

	// Tracks the region state and register contents, predicts each result.
	class match_tracker;
		logic [mbps_pkg::NUM_WORDS-1:0][mbps_pkg::WORD_W-1:0] pattern;
		logic [mbps_pkg::MASK_W-1:0] care;
		logic [mbps_pkg::LEN_W-1:0] length;
		logic [7:0] window [mbps_pkg::PAT_CAP];
		int unsigned fill;
		logic [mbps_pkg::OFFSET_BITS-1:0] position;
		bit matched;
		mbps_pkg::res_t expected_hits [$];
		int mismatches;
		int found_count;
		int miss_count;
		int byte_count;
		int write_count;

		function new();
			pattern = '0;
			care = '0;
			length = mbps_pkg::LEN_W'(1);
			mismatches = 0;
			found_count = 0;
			miss_count = 0;
			byte_count = 0;
			write_count = 0;
			clear_region();
		endfunction

		function void clear_region();
			foreach (window[k])
				window[k] = 8'h00;
			fill = 0;
			position = '0;
			matched = 1'b0;
		endfunction

		function int unsigned eff_length();
			if (length == 0)
				return 1;
			if (length > mbps_pkg::PAT_CAP)
				return mbps_pkg::PAT_CAP;
			return length;
		endfunction

		function logic [7:0] pattern_byte(int unsigned i);
			return pattern[i >> 3][(i & 7) * 8 +: 8];
		endfunction

		function void write_reg(logic [mbps_pkg::IDX_W-1:0] idx, logic [63:0] value);
			write_count++;
			case (idx)
				mbps_pkg::REG_PATTERN_0: pattern[0] = value;
				mbps_pkg::REG_PATTERN_1: pattern[1] = value;
				mbps_pkg::REG_PATTERN_2: pattern[2] = value;
				mbps_pkg::REG_PATTERN_3: pattern[3] = value;
				mbps_pkg::REG_CARE_MASK: care = value[mbps_pkg::MASK_W-1:0];
				mbps_pkg::REG_LENGTH: length = value[mbps_pkg::LEN_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_byte(logic [7:0] b, logic lst);
			int unsigned len;
			int unsigned k;
			logic [mbps_pkg::OFFSET_BITS-1:0] cur;
			bit hit;
			mbps_pkg::res_t r;
			byte_count++;
			if (matched) begin
				if (lst)
					clear_region();
				return;
			end
			cur = position;
			len = eff_length();
			for (k = mbps_pkg::PAT_CAP - 1; k > 0; k--)
				window[k] = window[k - 1];
			window[0] = b;
			if (fill < mbps_pkg::PAT_CAP)
				fill++;
			if (position != '1)
				position++;
			hit = (fill >= len);
			for (k = 0; k < len && hit; k++)
				if (care[k] && window[len - 1 - k] != pattern_byte(k))
					hit = 1'b0;
			if (hit) begin
				r.found = 1'b1;
				r.offset = mbps_pkg::OFF_OUT_W'(cur - (len - 1));
				expected_hits.push_back(r);
				if (lst)
					clear_region();
				else
					matched = 1'b1;
			end else if (lst) begin
				r.found = 1'b0;
				r.offset = '0;
				expected_hits.push_back(r);
				clear_region();
			end
		endfunction

		function void check_result(logic found, logic [mbps_pkg::OFF_OUT_W-1:0] offset);
			mbps_pkg::res_t r;
			if (expected_hits.size() == 0) begin
				$error("unexpected result: found=%0d match_offset=%0d", found, offset);
				mismatches++;
				return;
			end
			r = expected_hits[0];
			expected_hits.delete(0);
			if (found !== r.found) begin
				$error("found: expected %0d, actual %0d", r.found, found);
				mismatches++;
			end
			if (offset !== r.offset) begin
				$error("match_offset: expected %0d, actual %0d", r.offset, offset);
				mismatches++;
			end
			if (r.found)
				found_count++;
			else
				miss_count++;
		endfunction

		function int pending();
			return expected_hits.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [7:0] s_tdata;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [31:0] m_tdata;
	logic [0:0] m_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [63:0] cfg_data;

	match_tracker scan;
	bit calm;
	bit hold_request;
	int idle_cycles;

	masked_byte_pattern_scan dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Offer one byte, with an occasional gap before it; return once it is taken.
	task automatic send_byte(input logic [7:0] b, input logic lst);
		int gap;
		@(negedge clk);
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 10);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= lst;
		do @(posedge clk); while (!s_tready);
		scan.note_byte(b, lst);
	endtask

	task automatic send_region(input logic [7:0] bytes [$]);
		foreach (bytes[k])
			send_byte(bytes[k], k == bytes.size() - 1);
	endtask

	task automatic write_reg(input logic [mbps_pkg::IDX_W-1:0] idx, input logic [63:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		scan.write_reg(idx, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Stop offering, let every expected result arrive, then let the pipeline settle.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (scan.pending() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Random bytes, mostly with the pattern planted somewhere; some plants are broken.
	task automatic send_random_region(output int sent);
		int unsigned len;
		int unsigned rl;
		int unsigned at;
		int unsigned mode;
		int unsigned k;
		logic [7:0] bytes [$];
		len = scan.eff_length();
		mode = $urandom_range(0, 9);
		rl = ($urandom_range(0, 19) == 0) ? $urandom_range(80, 300) : $urandom_range(1, len + 24);
		for (k = 0; k < rl; k++)
			bytes.push_back(8'($urandom_range(0, 255)));
		if (mode < 8 && rl >= len) begin
			at = $urandom_range(0, rl - len);
			for (k = 0; k < len; k++)
				if (scan.care[k])
					bytes[at + k] = scan.pattern_byte(k);
			if (mode >= 6)
				bytes[at + $urandom_range(0, len - 1)] ^= 8'($urandom_range(1, 255));
		end
		send_region(bytes);
		sent = rl;
	endtask

	// Result side: random stall bursts, plus one long hold-off on request.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_request = 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 9)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			scan.check_result(m_tuser[0], m_tdata);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int p;
		int budget;
		int n;
		int unsigned len_val;
		logic [63:0] value;
		logic [mbps_pkg::MASK_W-1:0] care_val;
		logic [mbps_pkg::NUM_WORDS-1:0][mbps_pkg::WORD_W-1:0] words;

		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		hold_request = 1'b0;
		idle_cycles = 0;
		scan = new();

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset defaults: one wildcard byte, so the first byte of every region matches.
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h3C, 1'b1);
		send_byte(8'hA5, 1'b1);
		drain();

		write_reg(mbps_pkg::REG_PATTERN_0, 64'h0000_0000_A55A_FF00);
		write_reg(mbps_pkg::REG_PATTERN_1, '1);
		write_reg(mbps_pkg::REG_PATTERN_2, '1);
		write_reg(mbps_pkg::REG_PATTERN_3, '1);
		write_reg(mbps_pkg::REG_CARE_MASK, 64'h0000_000F);
		write_reg(mbps_pkg::REG_LENGTH, 64'd4);
		write_reg(mbps_pkg::IDX_W'(mbps_pkg::REG_LENGTH + 1), '1);
		// match mid-region then ignored bytes, end without match, match on last byte
		send_region('{8'h11, 8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h22, 8'h33});
		send_region('{8'h00, 8'hFF, 8'h5A});
		send_region('{8'h00, 8'hFF, 8'h5A, 8'hA5});
		drain();

		// zero length acts as one byte
		write_reg(mbps_pkg::REG_PATTERN_0, 64'h7E);
		write_reg(mbps_pkg::REG_CARE_MASK, 64'h1);
		write_reg(mbps_pkg::REG_LENGTH, 64'd0);
		send_region('{8'h01, 8'h7E, 8'h00});
		drain();

		// Every one-byte region gives a result; hold the result side to back up the input.
		write_reg(mbps_pkg::REG_PATTERN_0, {$urandom(), $urandom()});
		write_reg(mbps_pkg::REG_LENGTH, 64'd1);
		hold_request = 1'b1;
		for (n = 0; n < PRESSURE_REGIONS; n++)
			send_byte(8'($urandom_range(0, 255)), 1'b1);
		drain();

		for (p = 0; p < NUM_PHASES; p++) begin
			calm = (p == NUM_PHASES - 1);
			case (p % 4)
				0: words = '0;
				1: words = '1;
				default: begin
					for (int w = 0; w < mbps_pkg::NUM_WORDS; w++)
						words[w] = {$urandom(), $urandom()};
				end
			endcase
			case (p % 5)
				0: care_val = '0;
				1: care_val = '1;
				default: care_val = $urandom() | $urandom();
			endcase
			case (p % 6)
				0: len_val = 1;
				1: len_val = mbps_pkg::PAT_CAP;
				2: len_val = 0;
				3: len_val = $urandom_range(mbps_pkg::PAT_CAP + 1, (1 << mbps_pkg::LEN_W) - 1);
				default: len_val = $urandom_range(2, 12);
			endcase
			write_reg(mbps_pkg::REG_PATTERN_0, words[0]);
			write_reg(mbps_pkg::REG_PATTERN_1, words[1]);
			write_reg(mbps_pkg::REG_PATTERN_2, words[2]);
			write_reg(mbps_pkg::REG_PATTERN_3, words[3]);
			// junk above the register width must be dropped
			write_reg(mbps_pkg::REG_CARE_MASK, {$urandom(), care_val});
			value = {$urandom(), $urandom()};
			value[mbps_pkg::LEN_W-1:0] = mbps_pkg::LEN_W'(len_val);
			write_reg(mbps_pkg::REG_LENGTH, value);
			if (p % 3 == 0)
				write_reg(mbps_pkg::IDX_W'(mbps_pkg::REG_LENGTH + 1 + $urandom_range(0, 1)),
					{$urandom(), $urandom()});
			budget = 0;
			while (budget < PHASE_BYTES) begin
				send_random_region(n);
				budget += n;
			end
			drain();
		end

		$display("Scanned %0d bytes over %0d register writes, lengths from zero to past the window.",
			scan.byte_count, scan.write_count);
		$display("Regions with a match: %0d, regions ending without one: %0d.",
			scan.found_count, scan.miss_count);
		if (scan.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/mbps_pkg.sv
sv/mbps_cmp.sv
sv/mbps_skid.sv
sv/masked_byte_pattern_scan.sv
sv/mbps_check.sv
tb/testbench.sv
